[rtl/dynamic_csr_graph_store_top_defines.svh]
// ----------------------------------------------------------------------------
// dynamic_csr_graph_store_top_defines
// assertion macros shared by the graph store rtl
// ----------------------------------------------------------------------------
`ifndef DYNAMIC_CSR_GRAPH_STORE_TOP_DEFINES_SVH
`define DYNAMIC_CSR_GRAPH_STORE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DCSR_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dcsr assertion failed");
`define DCSR_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dcsr assertion failed");
`else
`define DCSR_ASSERT_IMP(name, clk, rstn, ante, cons)
`define DCSR_ASSERT_NXT(name, clk, rstn, ante, cons)
`endif

`endif

[rtl/dcsr_pkg.sv]
// ----------------------------------------------------------------------------
// dcsr_pkg
// types, codes and defaults of the compressed sparse row graph store
// ----------------------------------------------------------------------------
package dcsr_pkg;

    localparam int DEF_NODE_SLOTS = 1024;
    localparam int DEF_EDGE_SLOTS = 4096;
    localparam int DEF_MAX_LIST   = 64;

    localparam logic [12:0] RST_EDGE_CAP    = 13'd4096;
    localparam logic [10:0] RST_NODE_CAP    = 11'd1024;
    localparam logic [6:0]  RST_COMPACT_PCT = 7'd25;

    typedef enum logic [1:0] {
        CFG_EDGE_CAP    = 2'd0,
        CFG_NODE_CAP    = 2'd1,
        CFG_COMPACT_PCT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MODE_ADD_NODE = 3'd0,
        MODE_ADD_EDGE = 3'd1,
        MODE_REMOVE   = 3'd2,
        MODE_UPDATE   = 3'd3,
        MODE_HAS_EDGE = 3'd4,
        MODE_LIST     = 3'd5,
        MODE_COMPACT  = 3'd6,
        MODE_NOP      = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NODE_RANGE = 2'd1,
        ST_NO_SPACE   = 2'd2,
        ST_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_POS,
        S_ADD_SHIFT_CHK,
        S_ADD_SHIFT_WR,
        S_ADD_ROW_CHK,
        S_ADD_ROW_WR,
        S_EMIT_OK,
        S_FIND_S,
        S_FIND_E,
        S_FIND_CHK,
        S_FIND_TEST,
        S_FIND_DONE,
        S_REM_CHK,
        S_CMP_NODE_CHK,
        S_CMP_END,
        S_CMP_CHK,
        S_CMP_MOVE,
        S_LIST_S,
        S_LIST_E,
        S_LIST_CHK,
        S_LIST_TEST
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_NODE_ADD,
        OP_RD_ROW_NEXT,
        OP_RD_ROW_SRC,
        OP_ADD_POS,
        OP_SHIFT_RD,
        OP_SHIFT_WR,
        OP_ROW_INIT,
        OP_ROW_RD,
        OP_ROW_INC,
        OP_ADD_PUT,
        OP_FIND_S,
        OP_FIND_E,
        OP_EDGE_RD,
        OP_FIND_TEST,
        OP_SET_WEIGHT,
        OP_KILL,
        OP_CMP_INIT,
        OP_ROW_RD_NEXT,
        OP_CMP_END,
        OP_CMP_MOVE,
        OP_CMP_ROW,
        OP_CMP_FINISH,
        OP_LIST_E,
        OP_LIST_TEST
    } dp_op_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_PLAIN,
        EMIT_NODE,
        EMIT_EXISTS,
        EMIT_NEIGHBOR
    } emit_t;

    typedef struct packed {
        logic        dead;
        logic [9:0]  dest;
        logic [15:0] kind;
        logic [31:0] weight;
    } edge_word_t;

    typedef struct packed {
        dp_op_t  op;
        emit_t   emit;
        status_t st;
        logic    last;
    } dcsr_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  node_full;
        logic  edge_full;
        logic  src_ok;
        logic  dst_ok;
        logic  dead_nz;
        logic  idx_gt_pos;
        logic  idx_lt_end;
        logic  node_le_used;
        logic  node_lt_used;
        logic  hit;
        logic  live_hit;
        logic  found;
        logic  over_thresh;
        logic  cnt_lt_limit;
        logic  pend_valid;
    } dcsr_sts_t;

endpackage

[rtl/dcsr_ram.sv]
// ----------------------------------------------------------------------------
// dcsr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module dcsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/dcsr_ctrl.sv]
// ----------------------------------------------------------------------------
// dcsr_ctrl
// sequencer of the graph store: walks each operation through datapath steps
// ----------------------------------------------------------------------------
module dcsr_ctrl import dcsr_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  dcsr_sts_t sts,
    output dcsr_cmd_t cmd,
    output logic      busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, emit: EMIT_NONE, st: ST_OK, last: 1'b1};
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                if (sts.mode == MODE_ADD_NODE)
                begin
                    if (sts.node_full)
                    begin
                        cmd.emit = EMIT_PLAIN;
                        cmd.st   = ST_NO_SPACE;
                    end
                    else
                    begin
                        cmd.op   = OP_NODE_ADD;
                        cmd.emit = EMIT_NODE;
                    end
                end
                else if (sts.mode == MODE_NOP)
                begin
                    cmd.emit = EMIT_PLAIN;
                end
                else if (sts.mode == MODE_COMPACT)
                begin
                    if (sts.dead_nz)
                    begin
                        cmd.op     = OP_CMP_INIT;
                        state_next = S_CMP_NODE_CHK;
                    end
                    else
                    begin
                        cmd.emit = EMIT_PLAIN;
                    end
                end
                else if (!sts.src_ok || (sts.mode == MODE_ADD_EDGE && !sts.dst_ok))
                begin
                    cmd.emit = EMIT_PLAIN;
                    cmd.st   = ST_NODE_RANGE;
                end
                else if (sts.mode == MODE_ADD_EDGE)
                begin
                    if (sts.edge_full)
                    begin
                        cmd.emit = EMIT_PLAIN;
                        cmd.st   = ST_NO_SPACE;
                    end
                    else
                    begin
                        cmd.op     = OP_RD_ROW_NEXT;
                        state_next = S_ADD_POS;
                    end
                end
                else if (sts.mode == MODE_LIST)
                begin
                    cmd.op     = OP_RD_ROW_SRC;
                    state_next = S_LIST_S;
                end
                else
                begin
                    cmd.op     = OP_RD_ROW_SRC;
                    state_next = S_FIND_S;
                end
            end
            S_ADD_POS:
            begin
                cmd.op     = OP_ADD_POS;
                state_next = S_ADD_SHIFT_CHK;
            end
            S_ADD_SHIFT_CHK:
            begin
                if (sts.idx_gt_pos)
                begin
                    cmd.op     = OP_SHIFT_RD;
                    state_next = S_ADD_SHIFT_WR;
                end
                else
                begin
                    cmd.op     = OP_ROW_INIT;
                    state_next = S_ADD_ROW_CHK;
                end
            end
            S_ADD_SHIFT_WR:
            begin
                cmd.op     = OP_SHIFT_WR;
                state_next = S_ADD_SHIFT_CHK;
            end
            S_ADD_ROW_CHK:
            begin
                if (sts.node_le_used)
                begin
                    cmd.op     = OP_ROW_RD;
                    state_next = S_ADD_ROW_WR;
                end
                else
                begin
                    cmd.op     = OP_ADD_PUT;
                    state_next = S_EMIT_OK;
                end
            end
            S_ADD_ROW_WR:
            begin
                cmd.op     = OP_ROW_INC;
                state_next = S_ADD_ROW_CHK;
            end
            S_EMIT_OK:
            begin
                cmd.emit   = EMIT_PLAIN;
                state_next = S_IDLE;
            end
            S_FIND_S:
            begin
                cmd.op     = OP_FIND_S;
                state_next = S_FIND_E;
            end
            S_FIND_E:
            begin
                cmd.op     = OP_FIND_E;
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (sts.idx_lt_end)
                begin
                    cmd.op     = OP_EDGE_RD;
                    state_next = S_FIND_TEST;
                end
                else
                begin
                    state_next = S_FIND_DONE;
                end
            end
            S_FIND_TEST:
            begin
                cmd.op     = OP_FIND_TEST;
                state_next = sts.hit ? S_FIND_DONE : S_FIND_CHK;
            end
            S_FIND_DONE:
            begin
                state_next = S_IDLE;
                if (sts.mode == MODE_HAS_EDGE)
                begin
                    cmd.emit = EMIT_EXISTS;
                end
                else if (!sts.found)
                begin
                    cmd.emit = EMIT_PLAIN;
                    cmd.st   = ST_NOT_FOUND;
                end
                else if (sts.mode == MODE_UPDATE)
                begin
                    cmd.op     = OP_SET_WEIGHT;
                    state_next = S_EMIT_OK;
                end
                else
                begin
                    cmd.op     = OP_KILL;
                    state_next = S_REM_CHK;
                end
            end
            S_REM_CHK:
            begin
                if (sts.over_thresh)
                begin
                    cmd.op     = OP_CMP_INIT;
                    state_next = S_CMP_NODE_CHK;
                end
                else
                begin
                    cmd.emit   = EMIT_PLAIN;
                    state_next = S_IDLE;
                end
            end
            S_CMP_NODE_CHK:
            begin
                if (sts.node_lt_used)
                begin
                    cmd.op     = OP_ROW_RD_NEXT;
                    state_next = S_CMP_END;
                end
                else
                begin
                    cmd.op     = OP_CMP_FINISH;
                    state_next = S_EMIT_OK;
                end
            end
            S_CMP_END:
            begin
                cmd.op     = OP_CMP_END;
                state_next = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                if (sts.idx_lt_end)
                begin
                    cmd.op     = OP_EDGE_RD;
                    state_next = S_CMP_MOVE;
                end
                else
                begin
                    cmd.op     = OP_CMP_ROW;
                    state_next = S_CMP_NODE_CHK;
                end
            end
            S_CMP_MOVE:
            begin
                cmd.op     = OP_CMP_MOVE;
                state_next = S_CMP_CHK;
            end
            S_LIST_S:
            begin
                cmd.op     = OP_FIND_S;
                state_next = S_LIST_E;
            end
            S_LIST_E:
            begin
                cmd.op     = OP_LIST_E;
                state_next = S_LIST_CHK;
            end
            S_LIST_CHK:
            begin
                if (sts.idx_lt_end && sts.cnt_lt_limit)
                begin
                    cmd.op     = OP_EDGE_RD;
                    state_next = S_LIST_TEST;
                end
                else
                begin
                    cmd.emit   = sts.pend_valid ? EMIT_NEIGHBOR : EMIT_PLAIN;
                    state_next = S_IDLE;
                end
            end
            S_LIST_TEST:
            begin
                cmd.op = OP_LIST_TEST;
                if (sts.live_hit && sts.pend_valid)
                begin
                    cmd.emit = EMIT_NEIGHBOR;
                    cmd.last = 1'b0;
                end
                state_next = S_LIST_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/dcsr_datapath.sv]
// ----------------------------------------------------------------------------
// dcsr_datapath
// row start and edge memories, counters, walk registers and result register
// ----------------------------------------------------------------------------
module dcsr_datapath import dcsr_pkg::*; #(
    parameter int NODE_SLOTS = DEF_NODE_SLOTS,
    parameter int EDGE_SLOTS = DEF_EDGE_SLOTS,
    parameter int MAX_LIST   = DEF_MAX_LIST
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         mode,
    input  logic [9:0]         src_id,
    input  logic [9:0]         dst_id,
    input  logic [15:0]        edge_kind,
    input  logic signed [31:0] weight,
    input  logic [6:0]         neighbor_limit,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [12:0]        cfg_wdata,
    input  dcsr_cmd_t          cmd,
    output dcsr_sts_t          sts,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic [9:0]         new_node_id,
    output logic               edge_exists,
    output logic [9:0]         neighbor_node,
    output logic               neighbor_valid,
    output logic [6:0]         neighbor_count,
    output logic               last,
    output logic               compacted,
    output logic [12:0]        live_edges
);

    localparam int NW  = $clog2(NODE_SLOTS + 1);
    localparam int NIW = NW + 1;
    localparam int RAW = NW;
    localparam int EW  = $clog2(EDGE_SLOTS + 1);
    localparam int EAW = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
    localparam int LW  = $clog2(MAX_LIST + 1);
    localparam int MW  = EW + 7;
    localparam int EWD = $bits(edge_word_t);

    // memories
    logic           row_we;
    logic [RAW-1:0] row_waddr;
    logic [EW-1:0]  row_wdata;
    logic           row_re;
    logic [RAW-1:0] row_raddr;
    logic [EW-1:0]  row_rdata;
    logic           edge_we;
    logic [EAW-1:0] edge_waddr;
    edge_word_t     edge_wdata;
    logic           edge_re;
    logic [EAW-1:0] edge_raddr;
    edge_word_t     edge_rdata;

    dcsr_ram #(.WIDTH(EW), .DEPTH(NODE_SLOTS + 1)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    dcsr_ram #(.WIDTH(EWD), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .re    (edge_re),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // registers
    logic [12:0]    edge_cap_reg, edge_cap_next;
    logic [10:0]    node_cap_reg, node_cap_next;
    logic [6:0]     pct_reg, pct_next;
    mode_t          mode_reg, mode_next;
    logic [9:0]     src_reg, src_next;
    logic [9:0]     dst_reg, dst_next;
    logic [15:0]    kind_reg, kind_next;
    logic [31:0]    weight_reg, weight_next;
    logic [LW-1:0]  limit_reg, limit_next;
    logic [NW-1:0]  nodes_used_reg, nodes_used_next;
    logic [EW-1:0]  edges_used_reg, edges_used_next;
    logic [EW-1:0]  live_reg, live_next;
    logic [EW-1:0]  dead_reg, dead_next;
    logic [EW-1:0]  idx_reg, idx_next;
    logic [EW-1:0]  end_reg, end_next;
    logic [EW-1:0]  pos_reg, pos_next;
    logic [EW-1:0]  fill_reg, fill_next;
    logic [EW-1:0]  old_start_reg, old_start_next;
    logic [NIW-1:0] node_idx_reg, node_idx_next;
    logic [LW-1:0]  cnt_reg, cnt_next;
    logic [9:0]     pend_reg, pend_next;
    logic           pend_valid_reg, pend_valid_next;
    logic           found_reg, found_next;
    edge_word_t     fdata_reg, fdata_next;
    logic           comp_reg, comp_next;
    logic           row_zero_reg, row_zero_next;

    logic           res_valid_reg, res_valid_next;
    logic [1:0]     res_status_reg, res_status_next;
    logic [9:0]     res_id_reg, res_id_next;
    logic           res_exists_reg, res_exists_next;
    logic [9:0]     res_node_reg, res_node_next;
    logic           res_nvalid_reg, res_nvalid_next;
    logic [6:0]     res_count_reg, res_count_next;
    logic           res_last_reg, res_last_next;
    logic           res_comp_reg, res_comp_next;
    logic [12:0]    res_live_reg, res_live_next;

    logic [EW-1:0]  row_val;
    logic [EW-1:0]  bound;
    logic [10:0]    src_inc;

    assign row_val = row_zero_reg ? '0 : row_rdata;
    assign bound   = (row_val > edges_used_reg) ? edges_used_reg : row_val;
    assign src_inc = {1'b0, src_reg} + 11'd1;

    always_comb
    begin
        edge_cap_next   = edge_cap_reg;
        node_cap_next   = node_cap_reg;
        pct_next        = pct_reg;
        mode_next       = mode_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        kind_next       = kind_reg;
        weight_next     = weight_reg;
        limit_next      = limit_reg;
        nodes_used_next = nodes_used_reg;
        edges_used_next = edges_used_reg;
        live_next       = live_reg;
        dead_next       = dead_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        pos_next        = pos_reg;
        fill_next       = fill_reg;
        old_start_next  = old_start_reg;
        node_idx_next   = node_idx_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        found_next      = found_reg;
        fdata_next      = fdata_reg;
        comp_next       = comp_reg;
        row_zero_next   = row_zero_reg;

        row_we     = 1'b0;
        row_waddr  = '0;
        row_wdata  = '0;
        row_re     = 1'b0;
        row_raddr  = '0;
        edge_we    = 1'b0;
        edge_waddr = '0;
        edge_wdata = edge_rdata;
        edge_re    = 1'b0;
        edge_raddr = '0;

        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_EDGE_CAP:    edge_cap_next = cfg_wdata;
                CFG_NODE_CAP:    node_cap_next = cfg_wdata[10:0];
                CFG_COMPACT_PCT: pct_next      = cfg_wdata[6:0];
                default:         ;
            endcase
        end

        case (cmd.op)
            OP_LOAD:
            begin
                mode_next   = mode_t'(mode);
                src_next    = src_id;
                dst_next    = dst_id;
                kind_next   = edge_kind;
                weight_next = weight;
                limit_next  = (32'(neighbor_limit) > 32'(MAX_LIST)) ?
                              LW'(MAX_LIST) : LW'(neighbor_limit);
                comp_next   = 1'b0;
            end
            OP_NODE_ADD:
            begin
                row_we          = 1'b1;
                row_waddr       = RAW'(NIW'(nodes_used_reg) + 1'b1);
                row_wdata       = edges_used_reg;
                nodes_used_next = nodes_used_reg + 1'b1;
            end
            OP_RD_ROW_NEXT:
            begin
                row_re    = 1'b1;
                row_raddr = RAW'(src_inc);
            end
            OP_RD_ROW_SRC:
            begin
                row_re    = 1'b1;
                row_raddr = RAW'(src_reg);
            end
            OP_ADD_POS:
            begin
                pos_next = bound;
                idx_next = edges_used_reg;
            end
            OP_SHIFT_RD:
            begin
                edge_re    = 1'b1;
                edge_raddr = EAW'(idx_reg - 1'b1);
            end
            OP_SHIFT_WR:
            begin
                edge_we    = 1'b1;
                edge_waddr = EAW'(idx_reg);
                edge_wdata = edge_rdata;
                idx_next   = idx_reg - 1'b1;
            end
            OP_ROW_INIT:
            begin
                node_idx_next = NIW'(src_inc);
            end
            OP_ROW_RD:
            begin
                row_re    = 1'b1;
                row_raddr = RAW'(node_idx_reg);
            end
            OP_ROW_INC:
            begin
                row_we        = 1'b1;
                row_waddr     = RAW'(node_idx_reg);
                row_wdata     = row_val + 1'b1;
                node_idx_next = node_idx_reg + 1'b1;
            end
            OP_ADD_PUT:
            begin
                edge_we         = 1'b1;
                edge_waddr      = EAW'(pos_reg);
                edge_wdata      = '{dead: 1'b0, dest: dst_reg, kind: kind_reg,
                                    weight: weight_reg};
                edges_used_next = edges_used_reg + 1'b1;
                live_next       = live_reg + 1'b1;
            end
            OP_FIND_S:
            begin
                idx_next  = bound;
                row_re    = 1'b1;
                row_raddr = RAW'(src_inc);
            end
            OP_FIND_E:
            begin
                end_next   = bound;
                found_next = 1'b0;
            end
            OP_EDGE_RD:
            begin
                edge_re    = 1'b1;
                edge_raddr = EAW'(idx_reg);
            end
            OP_FIND_TEST:
            begin
                idx_next = idx_reg + 1'b1;
                if (edge_rdata.dest == dst_reg && !edge_rdata.dead)
                begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    fdata_next = edge_rdata;
                end
            end
            OP_SET_WEIGHT:
            begin
                edge_we           = 1'b1;
                edge_waddr        = EAW'(pos_reg);
                edge_wdata        = fdata_reg;
                edge_wdata.weight = weight_reg;
            end
            OP_KILL:
            begin
                edge_we         = 1'b1;
                edge_waddr      = EAW'(pos_reg);
                edge_wdata      = fdata_reg;
                edge_wdata.dead = 1'b1;
                dead_next       = dead_reg + 1'b1;
                live_next       = live_reg - 1'b1;
            end
            OP_CMP_INIT:
            begin
                node_idx_next  = '0;
                fill_next      = '0;
                old_start_next = '0;
                comp_next      = 1'b1;
            end
            OP_ROW_RD_NEXT:
            begin
                row_re    = 1'b1;
                row_raddr = RAW'(node_idx_reg + 1'b1);
            end
            OP_CMP_END:
            begin
                end_next = bound;
                idx_next = old_start_reg;
            end
            OP_CMP_MOVE:
            begin
                idx_next = idx_reg + 1'b1;
                if (!edge_rdata.dead)
                begin
                    edge_we    = 1'b1;
                    edge_waddr = EAW'(fill_reg);
                    edge_wdata = edge_rdata;
                    fill_next  = fill_reg + 1'b1;
                end
            end
            OP_CMP_ROW:
            begin
                row_we         = 1'b1;
                row_waddr      = RAW'(node_idx_reg + 1'b1);
                row_wdata      = fill_reg;
                old_start_next = (end_reg > old_start_reg) ? end_reg : old_start_reg;
                node_idx_next  = node_idx_reg + 1'b1;
            end
            OP_CMP_FINISH:
            begin
                edges_used_next = fill_reg;
                live_next       = fill_reg;
                dead_next       = '0;
            end
            OP_LIST_E:
            begin
                end_next        = bound;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
            end
            OP_LIST_TEST:
            begin
                idx_next = idx_reg + 1'b1;
                if (!edge_rdata.dead)
                begin
                    cnt_next        = cnt_reg + 1'b1;
                    pend_next       = edge_rdata.dest;
                    pend_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (row_re)
        begin
            row_zero_next = (row_raddr == '0);
        end
    end

    // result register
    always_comb
    begin
        res_valid_next  = (cmd.emit != EMIT_NONE);
        res_status_next = cmd.st;
        res_id_next     = (cmd.emit == EMIT_NODE) ? 10'(nodes_used_reg) : '0;
        res_exists_next = (cmd.emit == EMIT_EXISTS) ? found_reg : 1'b0;
        res_node_next   = (cmd.emit == EMIT_NEIGHBOR) ? pend_reg : '0;
        res_nvalid_next = (cmd.emit == EMIT_NEIGHBOR);
        res_count_next  = (cmd.emit == EMIT_NEIGHBOR) ? 7'(cnt_reg) : '0;
        res_last_next   = cmd.last;
        res_comp_next   = comp_reg;
        res_live_next   = 13'(live_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cap_reg   <= RST_EDGE_CAP;
            node_cap_reg   <= RST_NODE_CAP;
            pct_reg        <= RST_COMPACT_PCT;
            nodes_used_reg <= '0;
            edges_used_reg <= '0;
            live_reg       <= '0;
            dead_reg       <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            edge_cap_reg   <= edge_cap_next;
            node_cap_reg   <= node_cap_next;
            pct_reg        <= pct_next;
            nodes_used_reg <= nodes_used_next;
            edges_used_reg <= edges_used_next;
            live_reg       <= live_next;
            dead_reg       <= dead_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        kind_reg       <= kind_next;
        weight_reg     <= weight_next;
        limit_reg      <= limit_next;
        idx_reg        <= idx_next;
        end_reg        <= end_next;
        pos_reg        <= pos_next;
        fill_reg       <= fill_next;
        old_start_reg  <= old_start_next;
        node_idx_reg   <= node_idx_next;
        cnt_reg        <= cnt_next;
        pend_reg       <= pend_next;
        pend_valid_reg <= pend_valid_next;
        found_reg      <= found_next;
        fdata_reg      <= fdata_next;
        comp_reg       <= comp_next;
        row_zero_reg   <= row_zero_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_exists_reg <= res_exists_next;
        res_node_reg   <= res_node_next;
        res_nvalid_reg <= res_nvalid_next;
        res_count_reg  <= res_count_next;
        res_last_reg   <= res_last_next;
        res_comp_reg   <= res_comp_next;
        res_live_reg   <= res_live_next;
    end

    // status to the sequencer
    always_comb
    begin
        sts.mode         = mode_reg;
        sts.node_full    = (32'(nodes_used_reg) >= 32'(NODE_SLOTS)) ||
                           (32'(nodes_used_reg) >= 32'(node_cap_reg));
        sts.edge_full    = (32'(edges_used_reg) >= 32'(EDGE_SLOTS)) ||
                           (32'(edges_used_reg) >= 32'(edge_cap_reg));
        sts.src_ok       = 32'(src_reg) < 32'(nodes_used_reg);
        sts.dst_ok       = 32'(dst_reg) < 32'(nodes_used_reg);
        sts.dead_nz      = (dead_reg != '0);
        sts.idx_gt_pos   = idx_reg > pos_reg;
        sts.idx_lt_end   = idx_reg < end_reg;
        sts.node_le_used = node_idx_reg <= NIW'(nodes_used_reg);
        sts.node_lt_used = node_idx_reg < NIW'(nodes_used_reg);
        sts.hit          = (edge_rdata.dest == dst_reg) && !edge_rdata.dead;
        sts.live_hit     = !edge_rdata.dead;
        sts.found        = found_reg;
        sts.over_thresh  = (MW'(dead_reg) * MW'(100)) >=
                           (MW'(pct_reg) * MW'(edges_used_reg));
        sts.cnt_lt_limit = cnt_reg < limit_reg;
        sts.pend_valid   = pend_valid_reg;
    end

    assign result_valid   = res_valid_reg;
    assign status         = res_status_reg;
    assign new_node_id    = res_id_reg;
    assign edge_exists    = res_exists_reg;
    assign neighbor_node  = res_node_reg;
    assign neighbor_valid = res_nvalid_reg;
    assign neighbor_count = res_count_reg;
    assign last           = res_last_reg;
    assign compacted      = res_comp_reg;
    assign live_edges     = res_live_reg;

endmodule

[rtl/dynamic_csr_graph_store_top.sv]
// ----------------------------------------------------------------------------
// dynamic_csr_graph_store_top
// directed graph store in compressed sparse row form with tombstoned edges
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken when busy is low, and every result
// is shown for exactly one cycle with result_valid high; results cannot be
// held off. All work goes through a row start memory and an edge memory, each
// with one write port and one registered read port, so the work of an item
// grows with the memory steps it needs: adding an edge moves every edge stored
// after the insert point and bumps the row start of every node after the
// source; removal, weight update and edge test scan the source row; a
// neighbor listing scans the row edges; a compaction walks every stored edge
// and every node.
// No clearing pass follows reset: row start entry 0 always reads as zero.
`include "dynamic_csr_graph_store_top_defines.svh"

module dynamic_csr_graph_store_top import dcsr_pkg::*; #(
    parameter int NODE_SLOTS = DEF_NODE_SLOTS,
    parameter int EDGE_SLOTS = DEF_EDGE_SLOTS,
    parameter int MAX_LIST   = DEF_MAX_LIST
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic [9:0]         src_id,
    input  logic [9:0]         dst_id,
    input  logic [15:0]        edge_kind,
    input  logic signed [31:0] weight,
    input  logic [6:0]         neighbor_limit,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_addr,
    input  logic [12:0]        cfg_wdata,
    output logic               result_valid,
    output logic [1:0]         status,
    output logic [9:0]         new_node_id,
    output logic               edge_exists,
    output logic [9:0]         neighbor_node,
    output logic               neighbor_valid,
    output logic [6:0]         neighbor_count,
    output logic               last,
    output logic               compacted,
    output logic [12:0]        live_edges
);

    dcsr_cmd_t cmd;
    dcsr_sts_t sts;

    dcsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    dcsr_datapath #(
        .NODE_SLOTS (NODE_SLOTS),
        .EDGE_SLOTS (EDGE_SLOTS),
        .MAX_LIST   (MAX_LIST)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (mode),
        .src_id         (src_id),
        .dst_id         (dst_id),
        .edge_kind      (edge_kind),
        .weight         (weight),
        .neighbor_limit (neighbor_limit),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .sts            (sts),
        .result_valid   (result_valid),
        .status         (status),
        .new_node_id    (new_node_id),
        .edge_exists    (edge_exists),
        .neighbor_node  (neighbor_node),
        .neighbor_valid (neighbor_valid),
        .neighbor_count (neighbor_count),
        .last           (last),
        .compacted      (compacted),
        .live_edges     (live_edges)
    );

    `DCSR_ASSERT_IMP(a_result_in_flight, clk, rst_n, result_valid, $past(busy))
    `DCSR_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `DCSR_ASSERT_IMP(a_neighbor_ok, clk, rst_n, result_valid && neighbor_valid, status == ST_OK)

endmodule

[tb/sv/tb_dynamic_csr_graph_store_top.sv]
// ----------------------------------------------------------------------------
// tb_dynamic_csr_graph_store_top
// self-checking bench for the compressed sparse row graph store
// ----------------------------------------------------------------------------
// A behavioral graph model predicts every result of each accepted transaction.
// A directed table covers the corner cases: some rows carry typed status and
// node id values. Random phases follow, each with its own capacities and
// compaction threshold. Results are checked in order, field by field.
module tb_dynamic_csr_graph_store_top;
    import dcsr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = DEF_NODE_SLOTS;
    localparam int EDGES = DEF_EDGE_SLOTS;
    localparam int LIST  = DEF_MAX_LIST;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic [1:0]  st;
        logic [9:0]  nid;
        logic        exists;
        logic [9:0]  nb;
        logic        nbv;
        logic [6:0]  cnt;
        logic        lst;
        logic        comp;
        logic [12:0] live;
    } graph_result_t;

    typedef struct {
        bit          cfg_on;
        cfg_idx_t    cfg_idx;
        logic [12:0] cfg_val;
        mode_t       m;
        logic [9:0]  src;
        logic [9:0]  dst;
        logic [15:0] kind;
        logic [31:0] wgt;
        logic [6:0]  lim;
        bit          typed;
        status_t     exp_st;
        logic [9:0]  exp_nid;
    } stim_row_t;

    logic clk, rst_n, start, busy;
    logic [2:0] mode;
    logic [9:0] src_id, dst_id;
    logic [15:0] edge_kind;
    logic signed [31:0] weight;
    logic [6:0] neighbor_limit;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [12:0] cfg_wdata;
    logic result_valid;
    logic [1:0] status;
    logic [9:0] new_node_id;
    logic edge_exists;
    logic [9:0] neighbor_node;
    logic neighbor_valid;
    logic [6:0] neighbor_count;
    logic last;
    logic compacted;
    logic [12:0] live_edges;

    dynamic_csr_graph_store_top i_dut (.*);

    // graph model state
    int unsigned row_start [0:NODES];
    logic [9:0]  e_dst  [0:EDGES-1];
    logic [15:0] e_kind [0:EDGES-1];
    logic [31:0] e_wgt  [0:EDGES-1];
    logic        e_dead [0:EDGES-1];
    int unsigned nodes_used, edges_used, live_count, dead_count;
    int unsigned edge_cap, node_cap, compact_pct;

    graph_result_t expected_q [$];
    stim_row_t table_rows [$];
    int mismatches;
    longint cycles;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned row_bound(int unsigned idx);
        return row_start[idx] > edges_used ? edges_used : row_start[idx];
    endfunction

    function automatic int unsigned find_live_edge(int unsigned s, int unsigned d);
        int unsigned lo, hi;
        lo = row_bound(s);
        hi = row_bound(s + 1);
        for (int unsigned i = lo; i < hi; i++)
            if (e_dst[i] == d && !e_dead[i])
                return i;
        return edges_used;
    endfunction

    function automatic void squeeze_tombstones();
        int unsigned fill, old_start, hi;
        fill = 0;
        old_start = 0;
        for (int unsigned n = 0; n < nodes_used; n++)
        begin
            hi = row_bound(n + 1);
            for (int unsigned i = old_start; i < hi; i++)
                if (!e_dead[i])
                begin
                    e_dst[fill]  = e_dst[i];
                    e_kind[fill] = e_kind[i];
                    e_wgt[fill]  = e_wgt[i];
                    e_dead[fill] = 1'b0;
                    fill++;
                end
            if (hi > old_start)
                old_start = hi;
            row_start[n + 1] = fill;
        end
        row_start[0] = 0;
        edges_used = fill;
        live_count = fill;
        dead_count = 0;
    endfunction

    function automatic void push_result(status_t st, logic [9:0] nid, logic ex,
                                        logic [9:0] nb, logic nbv, logic [6:0] cnt,
                                        logic lst, logic comp);
        graph_result_t r;
        r.st = st;
        r.nid = nid;
        r.exists = ex;
        r.nb = nb;
        r.nbv = nbv;
        r.cnt = cnt;
        r.lst = lst;
        r.comp = comp;
        r.live = live_count[12:0];
        expected_q.push_back(r);
    endfunction

    function automatic void predict_graph_op(mode_t m, int unsigned s, int unsigned d,
                                             logic [15:0] kind, logic [31:0] wgt,
                                             int unsigned lim);
        int unsigned ecap, ncap, pos, lo, hi, cnt;
        logic [9:0] found [$];
        logic did;
        ecap = edge_cap < EDGES ? edge_cap : EDGES;
        ncap = node_cap < NODES ? node_cap : NODES;
        if (m == MODE_ADD_NODE)
        begin
            if (nodes_used >= ncap)
                push_result(ST_NO_SPACE, 0, 0, 0, 0, 0, 1, 0);
            else
            begin
                row_start[nodes_used + 1] = edges_used;
                nodes_used++;
                push_result(ST_OK, 10'(nodes_used - 1), 0, 0, 0, 0, 1, 0);
            end
            return;
        end
        if (m == MODE_NOP)
        begin
            push_result(ST_OK, 0, 0, 0, 0, 0, 1, 0);
            return;
        end
        if (m == MODE_COMPACT)
        begin
            did = dead_count != 0;
            if (did)
                squeeze_tombstones();
            push_result(ST_OK, 0, 0, 0, 0, 0, 1, did);
            return;
        end
        if (s >= nodes_used || (m == MODE_ADD_EDGE && d >= nodes_used))
        begin
            push_result(ST_NODE_RANGE, 0, 0, 0, 0, 0, 1, 0);
            return;
        end
        case (m)
            MODE_ADD_EDGE:
            begin
                if (edges_used >= ecap)
                begin
                    push_result(ST_NO_SPACE, 0, 0, 0, 0, 0, 1, 0);
                    return;
                end
                pos = row_bound(s + 1);
                for (int unsigned i = edges_used; i > pos; i--)
                begin
                    e_dst[i]  = e_dst[i - 1];
                    e_kind[i] = e_kind[i - 1];
                    e_wgt[i]  = e_wgt[i - 1];
                    e_dead[i] = e_dead[i - 1];
                end
                for (int unsigned i = s + 1; i <= nodes_used; i++)
                    row_start[i]++;
                e_dst[pos]  = 10'(d);
                e_kind[pos] = kind;
                e_wgt[pos]  = wgt;
                e_dead[pos] = 1'b0;
                edges_used++;
                live_count++;
                push_result(ST_OK, 0, 0, 0, 0, 0, 1, 0);
            end
            MODE_REMOVE:
            begin
                pos = find_live_edge(s, d);
                if (pos >= edges_used)
                begin
                    push_result(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1, 0);
                    return;
                end
                e_dead[pos] = 1'b1;
                dead_count++;
                live_count--;
                did = longint'(dead_count) * 100 >= longint'(compact_pct) * edges_used;
                if (did)
                    squeeze_tombstones();
                push_result(ST_OK, 0, 0, 0, 0, 0, 1, did);
            end
            MODE_UPDATE:
            begin
                pos = find_live_edge(s, d);
                if (pos >= edges_used)
                    push_result(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1, 0);
                else
                begin
                    e_wgt[pos] = wgt;
                    push_result(ST_OK, 0, 0, 0, 0, 0, 1, 0);
                end
            end
            MODE_HAS_EDGE:
                push_result(ST_OK, 0, find_live_edge(s, d) < edges_used, 0, 0, 0, 1, 0);
            default:
            begin
                lo = row_bound(s);
                hi = row_bound(s + 1);
                if (lim > LIST)
                    lim = LIST;
                for (int unsigned i = lo; i < hi && found.size() < lim; i++)
                    if (!e_dead[i])
                        found.push_back(e_dst[i]);
                cnt = found.size();
                if (cnt == 0)
                    push_result(ST_OK, 0, 0, 0, 0, 0, 1, 0);
                for (int unsigned i = 0; i < cnt; i++)
                    push_result(ST_OK, 0, 0, found[i], 1, 7'(i + 1), i + 1 == cnt, 0);
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        graph_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: status %0d live %0d",
                             status, live_edges);
            end
            else
            begin
                want = expected_q.pop_front();
                if (status !== want.st || new_node_id !== want.nid
                    || edge_exists !== want.exists || neighbor_node !== want.nb
                    || neighbor_valid !== want.nbv || neighbor_count !== want.cnt
                    || last !== want.lst || compacted !== want.comp
                    || live_edges !== want.live)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected %p, ", want);
                        $display("got st %0d nid %0d ex %0d nb %0d nbv %0d cnt %0d",
                                 status, new_node_id, edge_exists, neighbor_node,
                                 neighbor_valid, neighbor_count,
                                 " last %0d comp %0d live %0d",
                                 last, compacted, live_edges);
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        while (expected_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [12:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        case (idx)
            CFG_EDGE_CAP:    edge_cap = val;
            CFG_NODE_CAP:    node_cap = val[10:0];
            CFG_COMPACT_PCT: compact_pct = val[6:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_op(mode_t m, logic [9:0] s, logic [9:0] d, logic [15:0] kind,
                           logic [31:0] wgt, logic [6:0] lim, int gap);
        repeat (gap) @(negedge clk);
        mode = m;
        src_id = s;
        dst_id = d;
        edge_kind = kind;
        weight = wgt;
        neighbor_limit = lim;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_graph_op(m, s, d, kind, wgt, lim);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic void add_row(mode_t m, logic [9:0] s, logic [9:0] d,
                                    logic [15:0] kind, logic [31:0] wgt, logic [6:0] lim,
                                    bit typed = 0, status_t st = ST_OK,
                                    logic [9:0] nid = 0);
        stim_row_t r;
        r.cfg_on = 0;
        r.cfg_idx = CFG_EDGE_CAP;
        r.cfg_val = 0;
        r.m = m;
        r.src = s;
        r.dst = d;
        r.kind = kind;
        r.wgt = wgt;
        r.lim = lim;
        r.typed = typed;
        r.exp_st = st;
        r.exp_nid = nid;
        table_rows.push_back(r);
    endfunction

    function automatic void add_cfg_row(cfg_idx_t idx, logic [12:0] val);
        stim_row_t r;
        r = '{cfg_on: 1, cfg_idx: idx, cfg_val: val, m: MODE_NOP, src: 0, dst: 0,
              kind: 0, wgt: 0, lim: 0, typed: 0, exp_st: ST_OK, exp_nid: 0};
        table_rows.push_back(r);
    endfunction

    function automatic logic [9:0] pick_dst(int unsigned s);
        int unsigned lo, hi;
        if (s < nodes_used && $urandom_range(0, 1))
        begin
            lo = row_bound(s);
            hi = row_bound(s + 1);
            if (hi > lo)
                return e_dst[$urandom_range(lo, hi - 1)];
        end
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom);
        return 10'($urandom_range(0, nodes_used));
    endfunction

    initial
    begin
        logic [12:0] ecaps [5] = '{13'd30, 13'd8191, 13'd4096, 13'd12, 13'd4096};
        logic [12:0] ncaps [5] = '{13'd2047, 13'd40, 13'd1024, 13'd60, 13'd0};
        logic [12:0] pcts  [5] = '{13'd0, 13'd100, 13'd50, 13'd127, 13'd25};
        mode_t m;
        int unsigned s, pick;
        int gap;

        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_NOP;
        src_id = 0;
        dst_id = 0;
        edge_kind = 0;
        weight = 0;
        neighbor_limit = 0;
        cfg_we = 1'b0;
        cfg_addr = CFG_EDGE_CAP;
        cfg_wdata = 0;
        for (int i = 0; i <= NODES; i++)
            row_start[i] = 0;
        nodes_used = 0;
        edges_used = 0;
        live_count = 0;
        dead_count = 0;
        edge_cap = RST_EDGE_CAP;
        node_cap = RST_NODE_CAP;
        compact_pct = RST_COMPACT_PCT;

        add_row(MODE_ADD_NODE, 0, 0, 0, 0, 0, 1, ST_OK, 0);
        add_row(MODE_ADD_NODE, 0, 0, 0, 0, 0, 1, ST_OK, 1);
        add_row(MODE_ADD_NODE, 0, 0, 0, 0, 0, 1, ST_OK, 2);
        add_row(MODE_ADD_EDGE, 0, 1, 16'hFFFF, 32'h7FFF_FFFF, 0);
        add_row(MODE_ADD_EDGE, 0, 2, 16'h0000, 32'h8000_0000, 0);
        add_row(MODE_ADD_EDGE, 2, 0, 16'h5A5A, 32'hFFFF_FFFF, 0);
        add_row(MODE_ADD_EDGE, 1, 10'h3FF, 0, 0, 0, 1, ST_NODE_RANGE);
        add_row(MODE_ADD_EDGE, 10'h3FF, 0, 0, 0, 0, 1, ST_NODE_RANGE);
        add_row(MODE_HAS_EDGE, 0, 1, 0, 0, 0);
        add_row(MODE_HAS_EDGE, 1, 0, 0, 0, 0);
        add_row(MODE_UPDATE, 0, 2, 0, 32'hFFFF_FFFF, 0);
        add_row(MODE_UPDATE, 1, 2, 0, 0, 0, 1, ST_NOT_FOUND);
        add_row(MODE_LIST, 0, 0, 0, 0, 7'h7F);
        add_row(MODE_LIST, 0, 0, 0, 0, 0);
        add_row(MODE_LIST, 1, 0, 0, 0, 5);
        add_row(MODE_REMOVE, 0, 1, 0, 0, 0);
        add_row(MODE_REMOVE, 0, 1, 0, 0, 0, 1, ST_NOT_FOUND);
        add_row(MODE_COMPACT, 0, 0, 0, 0, 0);
        add_row(MODE_NOP, 10'h3FF, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 7'h7F);
        add_row(MODE_LIST, 10'h3FF, 0, 0, 0, 64, 1, ST_NODE_RANGE);
        add_cfg_row(CFG_COMPACT_PCT, 127);
        add_row(MODE_REMOVE, 2, 0, 0, 0, 0);
        add_row(MODE_COMPACT, 0, 0, 0, 0, 0);
        add_cfg_row(CFG_NODE_CAP, 0);
        add_row(MODE_ADD_NODE, 0, 0, 0, 0, 0, 1, ST_NO_SPACE);
        add_cfg_row(CFG_EDGE_CAP, 0);
        add_row(MODE_ADD_EDGE, 0, 1, 0, 0, 0, 1, ST_NO_SPACE);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_rows[i])
        begin
            if (table_rows[i].cfg_on)
                write_reg(table_rows[i].cfg_idx, table_rows[i].cfg_val);
            else
            begin
                send_op(table_rows[i].m, table_rows[i].src, table_rows[i].dst,
                        table_rows[i].kind, table_rows[i].wgt, table_rows[i].lim,
                        $urandom_range(0, 12));
                if (table_rows[i].typed)
                begin
                    expected_q[$].st = table_rows[i].exp_st;
                    expected_q[$].nid = table_rows[i].exp_nid;
                end
            end
        end

        for (int p = 0; p < 5; p++)
        begin
            write_reg(CFG_EDGE_CAP, ecaps[p]);
            write_reg(CFG_NODE_CAP, ncaps[p]);
            write_reg(CFG_COMPACT_PCT, pcts[p]);
            for (int k = 0; k < 16; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    m = MODE_ADD_NODE;
                else if (pick < 45)
                    m = MODE_ADD_EDGE;
                else if (pick < 60)
                    m = MODE_REMOVE;
                else if (pick < 70)
                    m = MODE_UPDATE;
                else if (pick < 80)
                    m = MODE_HAS_EDGE;
                else if (pick < 92)
                    m = MODE_LIST;
                else if (pick < 97)
                    m = MODE_COMPACT;
                else
                    m = MODE_NOP;
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, nodes_used);
                gap = (p % 2 == 1) ? 0 : $urandom_range(0, 12);
                send_op(m, 10'(s), pick_dst(s), 16'($urandom), $urandom,
                        7'($urandom_range(0, 127)), gap);
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
